/* rtl/core/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Default sizes
    localparam int NUM_BLOCKS_DEF = 256;
    localparam int MAX_RUN_DEF    = 64;

    // Fixed field widths
    localparam int SHIFT_W   = 4;
    localparam int SIZE_W    = 16;
    localparam int IN_IDX_W  = 8;
    localparam int STATUS_W  = 3;
    localparam int OUT_CNT_W = 9;
    localparam int NEED_W    = 7;    // holds any run length up to 64 blocks
    localparam int S_TDATA_W = 24;   // size_bytes, block_index
    localparam int M_TDATA_W = 24;   // status, granted_index, free_count, pad

    localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd4;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_OOM    = 3'd1,
        STAT_ZERO   = 3'd2,
        STAT_BIG    = 3'd3,
        STAT_DOUBLE = 3'd4
    } result_code_t;

    // Command kind decided by the front end
    typedef enum logic [1:0] {
        KIND_ALLOC,
        KIND_FREE,
        KIND_ZERO,
        KIND_BIG
    } kind_t;

    // One classified command
    typedef struct packed {
        kind_t                kind;
        logic [NEED_W-1:0]    needed;
        logic [IN_IDX_W-1:0]  block_index;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_POP,
        BK_SEND
    } back_state_t;

endpackage

/* rtl/core/bba_front.sv */
// ----------------------------------------------------------------------------
// bba_front
// Holds the block size register and classifies each incoming item.
// ----------------------------------------------------------------------------
module bba_front #(
    parameter int MAX_RUN = bba_pkg::MAX_RUN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bba_pkg::SHIFT_W-1:0]   cfg_wr_data,
    input  logic [bba_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    output bba_pkg::cmd_t                 cmd
);

    logic [bba_pkg::SHIFT_W-1:0]  shift_reg;
    logic [bba_pkg::SIZE_W-1:0]   size_bytes;
    logic [bba_pkg::IN_IDX_W-1:0] block_index;
    logic [bba_pkg::SIZE_W:0]     frac_mask;
    logic [bba_pkg::SIZE_W-1:0]   need_full;

    // Block size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= bba_pkg::SHIFT_RST;
        end else if (cfg_wr_en) begin
            shift_reg <= cfg_wr_data;
        end
    end

    assign size_bytes  = s_tdata[bba_pkg::SIZE_W-1:0];
    assign block_index = s_tdata[bba_pkg::SIZE_W +: bba_pkg::IN_IDX_W];

    // Round the byte size up to whole blocks
    assign frac_mask = ((bba_pkg::SIZE_W+1)'(1) << shift_reg) - (bba_pkg::SIZE_W+1)'(1);
    assign need_full = (size_bytes >> shift_reg)
                     + bba_pkg::SIZE_W'(|(size_bytes & frac_mask[bba_pkg::SIZE_W-1:0]));

    // Classify
    always_comb begin
        cmd.needed      = bba_pkg::NEED_W'(need_full);
        cmd.block_index = block_index;
        if (s_tuser) begin
            cmd.kind = bba_pkg::KIND_FREE;
        end else if (size_bytes == '0) begin
            cmd.kind = bba_pkg::KIND_ZERO;
        end else if (32'(need_full) > 32'(MAX_RUN)) begin
            cmd.kind = bba_pkg::KIND_BIG;
        end else begin
            cmd.kind = bba_pkg::KIND_ALLOC;
        end
    end

endmodule

/* rtl/core/bba_queue.sv */
// ----------------------------------------------------------------------------
// bba_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module bba_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  bba_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_pop,
    output bba_pkg::cmd_t rd_cmd
);

    localparam int PTR_W = (bba_pkg::QUEUE_DEPTH > 1) ? $clog2(bba_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(bba_pkg::QUEUE_DEPTH + 1);

    bba_pkg::cmd_t    entry_reg [bba_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_wr, do_rd;

    assign wr_ready = (fill_reg != CNT_W'(bba_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    // Pointer and fill updates
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr) begin
            wr_ptr_next = (32'(wr_ptr_reg) == bba_pkg::QUEUE_DEPTH - 1) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (32'(rd_ptr_reg) == bba_pkg::QUEUE_DEPTH - 1) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        fill_next = fill_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

/* rtl/core/bba_back.sv */
// ----------------------------------------------------------------------------
// bba_back
// Availability bitmap, free count, block search, index stack and result
// register. Carries out one queued command at a time.
// ----------------------------------------------------------------------------
module bba_back #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_RUN    = bba_pkg::MAX_RUN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  bba_pkg::cmd_t                 q_cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bba_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int SP_W  = $clog2(MAX_RUN + 1);
    localparam int AW    = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int PAD_W = bba_pkg::M_TDATA_W - bba_pkg::STATUS_W
                         - bba_pkg::IN_IDX_W - bba_pkg::OUT_CNT_W;

    bba_pkg::back_state_t state_reg, state_next;

    logic [NUM_BLOCKS-1:0]     avail_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [bba_pkg::NEED_W-1:0] remain_reg, remain_next;
    logic [SP_W-1:0]           sp_reg, sp_next, sp_dec;
    logic [IDX_W-1:0]          stack_mem [MAX_RUN];
    logic [IDX_W-1:0]          rd_data_reg;

    // Result register
    logic                          m_valid_reg, m_valid_next;
    bba_pkg::result_code_t         o_status_reg;
    logic [bba_pkg::IN_IDX_W-1:0]  o_index_reg;
    logic                          o_last_reg;
    logic [bba_pkg::OUT_CNT_W-1:0] o_count_reg;

    // Control from the output decoder
    logic                          out_ready;
    logic                          out_load;
    bba_pkg::result_code_t         out_status;
    logic [bba_pkg::IN_IDX_W-1:0]  out_index;
    logic                          out_last;
    logic [CNT_W-1:0]              out_count;
    logic                          set_en, clr_en, push_en, pop_rd;
    logic [IDX_W-1:0]              pe_idx;
    logic [IDX_W-1:0]              free_idx;
    logic                          free_bad;

    assign out_ready = !m_valid_reg || m_tready;
    assign sp_dec    = sp_reg - SP_W'(1);
    assign free_idx  = IDX_W'(q_cmd.block_index);
    assign free_bad  = (32'(q_cmd.block_index) >= NUM_BLOCKS) || avail_reg[free_idx];

    // Lowest free block
    always_comb begin
        pe_idx = '0;
        for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
            if (avail_reg[i]) begin
                pe_idx = IDX_W'(i);
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::BK_IDLE: begin
                if (q_valid && out_ready && q_cmd.kind == bba_pkg::KIND_ALLOC &&
                    32'(q_cmd.needed) <= 32'(count_reg)) begin
                    state_next = bba_pkg::BK_SEARCH;
                end
            end
            bba_pkg::BK_SEARCH: begin
                if (remain_reg == bba_pkg::NEED_W'(1)) begin
                    state_next = bba_pkg::BK_POP;
                end
            end
            bba_pkg::BK_POP: begin
                state_next = bba_pkg::BK_SEND;
            end
            bba_pkg::BK_SEND: begin
                if (out_ready) begin
                    state_next = (sp_reg == '0) ? bba_pkg::BK_IDLE : bba_pkg::BK_POP;
                end
            end
            default: begin
                state_next = bba_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb begin
        q_pop       = 1'b0;
        out_load    = 1'b0;
        out_status  = bba_pkg::STAT_OK;
        out_index   = '0;
        out_last    = 1'b1;
        out_count   = count_reg;
        set_en      = 1'b0;
        clr_en      = 1'b0;
        push_en     = 1'b0;
        pop_rd      = 1'b0;
        count_next  = count_reg;
        remain_next = remain_reg;
        sp_next     = sp_reg;
        case (state_reg)
            bba_pkg::BK_IDLE: begin
                if (q_valid && out_ready) begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        bba_pkg::KIND_ZERO: begin
                            out_load   = 1'b1;
                            out_status = bba_pkg::STAT_ZERO;
                        end
                        bba_pkg::KIND_BIG: begin
                            out_load   = 1'b1;
                            out_status = bba_pkg::STAT_BIG;
                        end
                        bba_pkg::KIND_FREE: begin
                            out_load  = 1'b1;
                            out_index = q_cmd.block_index;
                            if (free_bad) begin
                                out_status = bba_pkg::STAT_DOUBLE;
                            end else begin
                                set_en     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                out_count  = count_next;
                            end
                        end
                        bba_pkg::KIND_ALLOC: begin
                            if (32'(q_cmd.needed) > 32'(count_reg)) begin
                                out_load   = 1'b1;
                                out_status = bba_pkg::STAT_OOM;
                            end else begin
                                remain_next = q_cmd.needed;
                                sp_next     = '0;
                            end
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            bba_pkg::BK_SEARCH: begin
                clr_en      = 1'b1;
                push_en     = 1'b1;
                count_next  = count_reg - CNT_W'(1);
                remain_next = remain_reg - bba_pkg::NEED_W'(1);
                sp_next     = sp_reg + SP_W'(1);
            end
            bba_pkg::BK_POP: begin
                pop_rd  = 1'b1;
                sp_next = sp_dec;
            end
            bba_pkg::BK_SEND: begin
                if (out_ready) begin
                    out_load  = 1'b1;
                    out_index = bba_pkg::IN_IDX_W'(rd_data_reg);
                    out_last  = (sp_reg == '0);
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Control registers and bitmap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bba_pkg::BK_IDLE;
            avail_reg  <= '1;
            count_reg  <= CNT_W'(NUM_BLOCKS);
            remain_reg <= '0;
            sp_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            sp_reg     <= sp_next;
            if (set_en) begin
                avail_reg[free_idx] <= 1'b1;
            end
            if (clr_en) begin
                avail_reg[pe_idx] <= 1'b0;
            end
        end
    end

    // Found-index stack, emptied in reverse order
    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[sp_reg[AW-1:0]] <= pe_idx;
        end
        if (pop_rd) begin
            rd_data_reg <= stack_mem[sp_dec[AW-1:0]];
        end
    end

    // Result register
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_status_reg <= out_status;
            o_index_reg  <= out_index;
            o_last_reg   <= out_last;
            o_count_reg  <= bba_pkg::OUT_CNT_W'(out_count);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {PAD_W'(0), o_count_reg, o_index_reg, o_status_reg};

`ifndef SYNTH
    // Free count never exceeds the pool
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= NUM_BLOCKS)
        else $error("free count above pool size");

    // A search step always lands on a free block
    a_search_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bba_pkg::BK_SEARCH) |-> avail_reg[pe_idx])
        else $error("search with no free block");

    // Last search step hands over to the stack read
    a_search_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bba_pkg::BK_SEARCH && remain_reg == bba_pkg::NEED_W'(1))
        |=> (state_reg == bba_pkg::BK_POP))
        else $error("search did not end after last block");

    // Result register only loads when it is free or being drained
    a_load_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_ready)
        else $error("result overwritten");

    // A freed block is visible as free on the next cycle
    a_free_set: assert property (@(posedge aclk) disable iff (!aresetn)
        set_en |=> avail_reg[$past(free_idx)])
        else $error("freed block not marked");
`endif

endmodule

/* rtl/core/bitmap_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// Bitmap free-block allocator: allocates runs of the lowest free blocks and
// returns single blocks to the pool.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tuser selects the operation (0 allocate, 1 free),
//   tdata carries size_bytes and block_index, tlast marks the end of a freed
//   run and is informational. Result stream m_*: one item per result, tlast
//   on the final result of each input item.
//   cfg_wr_en/cfg_wr_data set log2 of the block size; write only when idle.
// Flow and throughput:
//   Items pass a two-entry command queue. A free, zero-size, too-large or
//   out-of-memory item is popped and its result loaded into the result
//   register, and the back end retires one such item per cycle while the
//   result register is free or draining. An allocation of n blocks runs a
//   priority-encoder search over the bitmap, one block per cycle, then pops
//   the index stack through its single read port (POP, then SEND) per result.
// Reset:
//   Every block free, count = NUM_BLOCKS, block shift 4, queue empty.
// Stall:
//   A stalled m_tready holds the result register; the back end waits, the
//   queue fills and s_tready drops when it is full.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_RUN    = bba_pkg::MAX_RUN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bba_pkg::SHIFT_W-1:0]   cfg_wr_data,   // block_shift
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bba_pkg::S_TDATA_W-1:0] s_tdata,       // size_bytes, block_index
    input  logic                          s_tuser,       // operation
    input  logic                          s_tlast,       // run_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bba_pkg::M_TDATA_W-1:0] m_tdata,       // status, granted_index,
                                                         // free_count, zero pad
    output logic                          m_tlast        // last
);

    bba_pkg::cmd_t front_cmd;
    bba_pkg::cmd_t head_cmd;
    logic          head_valid;
    logic          head_pop;

    // Freed-run marker carries no work here
    logic          run_last_unused;
    assign run_last_unused = s_tlast;

    bba_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (front_cmd)
    );

    bba_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_cmd   (front_cmd),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_cmd   (head_cmd)
    );

    bba_back #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .MAX_RUN    (MAX_RUN)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (head_valid),
        .q_pop    (head_pop),
        .q_cmd    (head_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
